[rtl/core/lca_pkg.sv]
// Shared constants, types and codes for the Game of Life unit.
`default_nettype none

package lca_pkg;

    // Grid geometry.
    localparam int GRID_COLS  = 64;
    localparam int GRID_ROWS  = 48;
    localparam int CELL_COUNT = GRID_COLS * GRID_ROWS;

    // Fixed field widths of the ports.
    localparam int OP_W     = 2;
    localparam int IN_COL_W = 6;
    localparam int IN_ROW_W = 6;
    localparam int POP_W    = 12;
    localparam int POP_MAX  = (1 << POP_W) - 1;

    // Internal widths derived from the geometry.
    localparam int ADDR_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int XCOL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int LIVE_W = $clog2(CELL_COUNT + 1);

    // The sweep runs from step 0 to SWEEP_LAST inclusive.
    localparam int SWEEP_LAST = GRID_ROWS + 3;
    localparam int SWP_W      = $clog2(SWEEP_LAST + 1);

    // Row population is summed in groups of columns, then across groups.
    localparam int GROUP_SIZE  = 8;
    localparam int GROUP_COUNT = (GRID_COLS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GRP_W       = $clog2(GROUP_SIZE + 1);
    localparam int ROWPOP_W    = $clog2(GRID_COLS + 1);

    // Neighbour counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    // Vertical three-cell window held in one column.
    typedef struct packed {
        logic up;
        logic mid;
        logic dn;
    } column_t;

    // Control from the sequencer to the row of cells.
    typedef struct packed {
        logic shift;
        logic count;
        logic sweep;
    } row_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/lca_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module lca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/lca_cell.sv]
// One column cell: holds a vertical window and computes the next state of its middle cell.
`default_nettype none

module lca_cell (
    input  wire logic               clk,
    input  wire logic               shift,
    input  wire logic               dn,
    input  wire lca_pkg::column_t   left,
    input  wire lca_pkg::column_t   right,
    output lca_pkg::column_t        window,
    output logic                    next_alive
);
    import lca_pkg::*;

    logic       up_reg;
    logic       mid_reg;
    logic [3:0] count;

    // The window slides down one row on every shift.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn;
        end
    end

    assign window = '{up: up_reg, mid: mid_reg, dn: dn};

    assign count = {3'b000, left.up}  + {3'b000, left.mid}  + {3'b000, left.dn}
                 + {3'b000, right.up} + {3'b000, right.mid} + {3'b000, right.dn}
                 + {3'b000, up_reg}   + {3'b000, dn};

    assign next_alive = (count == BIRTH_COUNT) || (mid_reg && (count == SURVIVE_COUNT));

endmodule

`default_nettype wire

[rtl/core/lca_cell_row.sv]
// Row of column cells with a two-stage population count of each new row.
`default_nettype none

module lca_cell_row (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lca_pkg::row_ctrl_t                  ctrl,
    input  wire logic [lca_pkg::GRID_COLS-1:0]       below_row,
    output logic      [lca_pkg::GRID_COLS-1:0]       next_row,
    output logic      [lca_pkg::ROWPOP_W-1:0]        row_pop
);
    import lca_pkg::*;

    column_t windows [GRID_COLS];
    column_t lefts   [GRID_COLS];
    column_t rights  [GRID_COLS];

    logic [GRP_W-1:0]    grp_reg  [GROUP_COUNT];
    logic [GRP_W-1:0]    grp_next [GROUP_COUNT];
    logic [ROWPOP_W-1:0] row_pop_reg;
    logic [ROWPOP_W-1:0] row_pop_next;

    // Each cell sees the windows of its two neighbours; off-grid columns are dead.
    for (genvar i = 0; i < GRID_COLS; i++)
    begin : g_cells
        if (i == 0)
        begin : g_left_edge
            assign lefts[i] = '0;
        end
        else
        begin : g_left_inner
            assign lefts[i] = windows[i-1];
        end

        if (i == GRID_COLS - 1)
        begin : g_right_edge
            assign rights[i] = '0;
        end
        else
        begin : g_right_inner
            assign rights[i] = windows[i+1];
        end

        lca_cell u_cell (
            .clk        (clk),
            .shift      (ctrl.shift),
            .dn         (below_row[i]),
            .left       (lefts[i]),
            .right      (rights[i]),
            .window     (windows[i]),
            .next_alive (next_row[i])
        );
    end

    always_comb
    begin
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                if (g * GROUP_SIZE + k < GRID_COLS)
                begin
                    grp_next[g] = grp_next[g]
                                + GRP_W'(next_row[(g * GROUP_SIZE + k) % GRID_COLS]);
                end
            end
            if (!ctrl.count)
            begin
                grp_next[g] = '0;
            end
        end
    end

    always_comb
    begin
        row_pop_next = '0;
        for (int g = 0; g < GROUP_COUNT; g++)
        begin
            row_pop_next = row_pop_next + ROWPOP_W'(grp_reg[g]);
        end
        if (!ctrl.sweep)
        begin
            row_pop_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                grp_reg[g] <= '0;
            end
            row_pop_reg <= '0;
        end
        else
        begin
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                grp_reg[g] <= grp_next[g];
            end
            row_pop_reg <= row_pop_next;
        end
    end

    assign row_pop = row_pop_reg;

endmodule

`default_nettype wire

[rtl/core/life_cellular_automaton_unit.sv]
// Top level of the Game of Life (B3/S23) unit: grid store, sweep sequencer and result port.
//
//   Channel   Ports                          Transfer
//   -------   ----------------------------   -----------------------------------------
//   request   start, operation, col, row     taken at a rising edge with start & !busy
//   result    done, cell_alive, population   valid for the one cycle in which done is high
//
// A set, clear or read request first reads the grid row from the row memory, then
// modifies it, writes it back and presents the result. In a generation step the
// row of column cells takes one grid row per cycle from the single row memory read
// port, and the population pipeline drains after the last row has been taken.
// Reset is asynchronous and active low. All rows read as dead after reset through a
// per-row valid flag, so no clearing pass is needed and requests may follow at once.
// The receiver cannot stall; busy stays high from the request until done.
`default_nettype none

module life_cellular_automaton_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lca_pkg::OP_W-1:0]      operation,
    input  wire logic [lca_pkg::IN_COL_W-1:0]  col,
    input  wire logic [lca_pkg::IN_ROW_W-1:0]  row,
    output logic                               busy,
    output logic                               done,
    output logic                               cell_alive,
    output logic      [lca_pkg::POP_W-1:0]     population
);
    import lca_pkg::*;

    state_t                 state_reg, state_next;
    logic [SWP_W-1:0]       sweep_reg, sweep_next;
    op_t                    op_reg, op_next;
    logic [XCOL_W-1:0]      col_reg, col_next;
    logic [ADDR_W-1:0]      row_reg, row_next;
    logic                   on_grid_reg, on_grid_next;
    logic [GRID_ROWS-1:0]   row_valid_reg, row_valid_next;
    logic                   rd_live_reg, rd_live_next;
    logic [LIVE_W-1:0]      live_total_reg, live_total_next;
    logic [LIVE_W-1:0]      acc_reg, acc_next;
    logic                   cell_alive_reg, cell_alive_next;
    logic                   done_reg, done_next;

    logic                   accept;
    logic                   req_on_grid;
    logic [ADDR_W-1:0]      req_row;
    logic                   compute;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [GRID_COLS-1:0]   wr_data;
    logic [ADDR_W-1:0]      rd_addr;
    logic [GRID_COLS-1:0]   rd_data;
    logic [GRID_COLS-1:0]   below_row;
    logic [GRID_COLS-1:0]   next_row;
    logic [ROWPOP_W-1:0]    row_pop;
    row_ctrl_t              row_ctrl;

    logic [GRID_COLS-1:0]   mod_word;
    logic                   old_bit;

    assign accept      = start && (state_reg == ST_IDLE);
    assign req_on_grid = (int'(col) < GRID_COLS) && (int'(row) < GRID_ROWS);
    assign req_row     = ADDR_W'(row);

    // A new row is produced once the window holds rows above, at and below it.
    assign compute = (state_reg == ST_SWEEP) && (int'(sweep_reg) >= 2)
                  && (int'(sweep_reg) <= GRID_ROWS + 1);

    // Rows never written since reset read as dead.
    assign below_row = rd_live_reg ? rd_data : '0;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (op_t'(operation) == OP_STEP) ? ST_SWEEP : ST_ACCESS;
                end
            end
            ST_ACCESS:
            begin
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (int'(sweep_reg) == SWEEP_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs: busy, memory addressing and row-of-cells control.
    always_comb
    begin
        busy           = 1'b1;
        rd_addr        = '0;
        rd_live_next   = 1'b0;
        row_ctrl.shift = 1'b0;
        row_ctrl.count = 1'b0;
        row_ctrl.sweep = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (req_on_grid)
                begin
                    rd_addr      = req_row;
                    rd_live_next = start && (op_t'(operation) != OP_STEP)
                                && row_valid_reg[req_row];
                end
            end
            ST_SWEEP:
            begin
                row_ctrl.shift = 1'b1;
                row_ctrl.count = compute;
                row_ctrl.sweep = 1'b1;
                if (int'(sweep_reg) < GRID_ROWS)
                begin
                    rd_addr      = ADDR_W'(sweep_reg);
                    rd_live_next = row_valid_reg[ADDR_W'(sweep_reg)];
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Read-modify-write word for set and clear.
    always_comb
    begin
        old_bit  = below_row[col_reg];
        mod_word = below_row;
        mod_word[col_reg] = (op_reg == OP_SET);
    end

    // Datapath.
    always_comb
    begin
        sweep_next      = sweep_reg;
        op_next         = op_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        on_grid_next    = on_grid_reg;
        row_valid_next  = row_valid_reg;
        live_total_next = live_total_reg;
        acc_next        = acc_reg;
        cell_alive_next = cell_alive_reg;
        done_next       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = mod_word;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(operation);
                    col_next        = XCOL_W'(col);
                    row_next        = req_row;
                    on_grid_next    = req_on_grid;
                    sweep_next      = '0;
                    cell_alive_next = 1'b0;
                end
            end
            ST_ACCESS:
            begin
                done_next = 1'b1;
                if (on_grid_reg)
                begin
                    case (op_reg)
                        OP_SET:
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = row_reg;
                            cell_alive_next = 1'b1;
                            row_valid_next[row_reg] = 1'b1;
                            if (!old_bit)
                            begin
                                live_total_next = live_total_reg + LIVE_W'(1);
                            end
                        end
                        OP_CLEAR:
                        begin
                            wr_en           = 1'b1;
                            wr_addr         = row_reg;
                            cell_alive_next = 1'b0;
                            row_valid_next[row_reg] = 1'b1;
                            if (old_bit)
                            begin
                                live_total_next = live_total_reg - LIVE_W'(1);
                            end
                        end
                        default:
                        begin
                            cell_alive_next = old_bit;
                        end
                    endcase
                end
                else
                begin
                    cell_alive_next = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + SWP_W'(1);
                acc_next   = (sweep_reg == '0) ? '0 : acc_reg + LIVE_W'(row_pop);
                if (compute)
                begin
                    wr_en   = 1'b1;
                    wr_addr = ADDR_W'(sweep_reg - SWP_W'(2));
                    wr_data = next_row;
                    row_valid_next[wr_addr] = 1'b1;
                    if (on_grid_reg && (wr_addr == row_reg))
                    begin
                        cell_alive_next = next_row[col_reg];
                    end
                end
            end
            ST_FINISH:
            begin
                live_total_next = acc_reg;
                done_next       = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_valid_reg  <= '0;
            live_total_reg <= '0;
            done_reg       <= 1'b0;
            rd_live_reg    <= 1'b0;
            sweep_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_valid_reg  <= row_valid_next;
            live_total_reg <= live_total_next;
            done_reg       <= done_next;
            rd_live_reg    <= rd_live_next;
            sweep_reg      <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        on_grid_reg    <= on_grid_next;
        acc_reg        <= acc_next;
        cell_alive_reg <= cell_alive_next;
    end

    // One grid row per memory word.
    lca_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    lca_cell_row u_cell_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (row_ctrl),
        .below_row (below_row),
        .next_row  (next_row),
        .row_pop   (row_pop)
    );

    assign done       = done_reg;
    assign cell_alive = cell_alive_reg;
    assign population = (int'(live_total_reg) > POP_MAX) ? POP_W'(POP_MAX)
                                                         : POP_W'(live_total_reg);

endmodule

`default_nettype wire

[dv/life_cellular_automaton_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the Game of Life unit: shadow grid, result prediction and comparison.
module life_cellular_automaton_unit_checker
    import lca_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire logic [OP_W-1:0]     operation,
    input  wire logic [IN_COL_W-1:0] col,
    input  wire logic [IN_ROW_W-1:0] row,
    input  wire logic                done,
    input  wire logic                cell_alive,
    input  wire logic [POP_W-1:0]    population,
    output int                       fail_count,
    output int                       awaited_count,
    output int                       compared_count
);

    typedef struct packed {
        logic             alive;
        logic [POP_W-1:0] pop;
    } outcome_t;

    logic        shadow_grid [GRID_ROWS][GRID_COLS];
    int unsigned shadow_live;
    outcome_t    awaited_q [$];
    int          fails;
    int          compared;

    // Live cells among the eight around (c, r); anything off the grid is dead.
    function automatic int unsigned live_neighbours(int c, int r);
        int unsigned n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && c + dc >= 0 && c + dc < GRID_COLS
                    && r + dr >= 0 && r + dr < GRID_ROWS)
                    n += shadow_grid[r + dr][c + dc];
            end
        end
        return n;
    endfunction

    // Every cell of the new generation is taken from the old grid.
    function automatic void advance_generation();
        logic        fresh [GRID_ROWS][GRID_COLS];
        int unsigned n;
        int unsigned total = 0;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                n = live_neighbours(c, r);
                fresh[r][c] = (n == BIRTH_COUNT) || (shadow_grid[r][c] && n == SURVIVE_COUNT);
                total += fresh[r][c];
            end
        end
        shadow_grid = fresh;
        shadow_live = total;
    endfunction

    function automatic outcome_t apply_request(op_t op, logic [IN_COL_W-1:0] c,
                                               logic [IN_ROW_W-1:0] r);
        logic     on_grid;
        outcome_t res;
        on_grid = (c < GRID_COLS) && (r < GRID_ROWS);
        case (op)
            OP_SET:
            begin
                if (on_grid && !shadow_grid[r][c])
                begin
                    shadow_grid[r][c] = 1'b1;
                    shadow_live++;
                end
            end
            OP_CLEAR:
            begin
                if (on_grid && shadow_grid[r][c])
                begin
                    shadow_grid[r][c] = 1'b0;
                    shadow_live--;
                end
            end
            OP_STEP: advance_generation();
            default: ;
        endcase
        res.alive = on_grid ? shadow_grid[r][c] : 1'b0;
        res.pop   = (shadow_live > POP_MAX) ? POP_W'(POP_MAX) : POP_W'(shadow_live);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            for (int r = 0; r < GRID_ROWS; r++)
                for (int c = 0; c < GRID_COLS; c++)
                    shadow_grid[r][c] = 1'b0;
            shadow_live = 0;
            awaited_q.delete();
            fails = 0;
            compared = 0;
            fail_count <= 0;
            awaited_count <= 0;
            compared_count <= 0;
        end
        else
        begin
            // A result leaving at this edge belongs to an earlier request than one entering.
            if (done)
            begin
                if (awaited_q.size() == 0)
                begin
                    fails++;
                    $error("result with no request outstanding: cell_alive %0d, population %0d",
                           cell_alive, population);
                end
                else
                begin
                    want = awaited_q.pop_front();
                    compared++;
                    if (cell_alive !== want.alive)
                    begin
                        fails++;
                        $error("cell_alive: expected %0d, actual %0d", want.alive, cell_alive);
                    end
                    if (population !== want.pop)
                    begin
                        fails++;
                        $error("population: expected %0d, actual %0d", want.pop, population);
                    end
                end
            end
            if (start && !busy)
                awaited_q.push_back(apply_request(op_t'(operation), col, row));
            fail_count <= fails;
            awaited_count <= awaited_q.size();
            compared_count <= compared;
        end
    end

endmodule

[dv/life_cellular_automaton_unit_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the Game of Life unit: clock, reset, request stimulus and verdict.
module life_cellular_automaton_unit_tb;
    import lca_pkg::*;

    // Total requests to issue, directed ones included.
    localparam int TOTAL_REQUESTS = 1950;
    // The slowest correct run has every request wait out a full generation sweep and
    // the longest sender gap; this limit leaves a wide margin over it.
    localparam int CYCLE_LIMIT = 800000;
    // Time to wait after the last result for any stray result to show.
    localparam int DRAIN_CYCLES = 64;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OP_W-1:0]     operation = OP_READ;
    logic [IN_COL_W-1:0] col = '0;
    logic [IN_ROW_W-1:0] row = '0;
    logic                busy;
    logic                done;
    logic                cell_alive;
    logic [POP_W-1:0]    population;

    int fail_count;
    int awaited_count;
    int compared_count;
    int cycle_count = 0;

    // Bookkeeping for the closing summary and the idling phases.
    int issued = 0;
    int steps_issued = 0;
    int off_grid_issued = 0;
    int idle_pct = 0;
    int calm_left = 0;

    always #1 clk = ~clk;

    life_cellular_automaton_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .col        (col),
        .row        (row),
        .busy       (busy),
        .done       (done),
        .cell_alive (cell_alive),
        .population (population)
    );

    life_cellular_automaton_unit_checker grid_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .col            (col),
        .row            (row),
        .done           (done),
        .cell_alive     (cell_alive),
        .population     (population),
        .fail_count     (fail_count),
        .awaited_count  (awaited_count),
        .compared_count (compared_count)
    );

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL life_cellular_automaton_unit");
            $finish;
        end
    end

    // Issues one request and returns at the edge where it is taken. The caller is left
    // at that edge with start still high, so a back-to-back request changes only the
    // payload, and start is never lowered and raised within one time step.
    task automatic issue_request(input op_t op, input int unsigned c, input int unsigned r);
        int unsigned gap;
        gap = 0;
        if (calm_left > 0)
            calm_left--;
        else if (idle_pct != 0 && $urandom_range(99) < 4)
            calm_left = $urandom_range(8, 30);
        else if ($urandom_range(99) < idle_pct)
        begin
            // Mostly short gaps, with now and then a long one that ends somewhere in
            // the middle of a generation sweep.
            if ($urandom_range(9) == 0)
                gap = $urandom_range(10, 60);
            else
                gap = $urandom_range(1, 6);
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        col       <= IN_COL_W'(c);
        row       <= IN_ROW_W'(r);
        @(posedge clk);
        while (busy)
            @(posedge clk);
        issued++;
        if (op == OP_STEP)
            steps_issued++;
        if (c >= GRID_COLS || r >= GRID_ROWS)
            off_grid_issued++;
    endtask

    // Seeds a random patch of cells, lets it evolve for a few generations and probes
    // it. The patch is often pushed against an edge of the grid, where neighbours
    // off the grid must count as dead.
    task automatic grow_patch();
        int unsigned w;
        int unsigned h;
        int unsigned c0;
        int unsigned r0;
        int unsigned fills;
        w = $urandom_range(3, 10);
        h = $urandom_range(3, 10);
        case ($urandom_range(3))
            0: c0 = 0;
            1: c0 = GRID_COLS - w;
            default: c0 = $urandom_range(0, GRID_COLS - w);
        endcase
        case ($urandom_range(3))
            0: r0 = 0;
            1: r0 = GRID_ROWS - h;
            default: r0 = $urandom_range(0, GRID_ROWS - h);
        endcase
        fills = $urandom_range(w * h / 4, w * h * 2 / 3);
        repeat (fills)
            issue_request(OP_SET, c0 + $urandom_range(w - 1), r0 + $urandom_range(h - 1));
        repeat ($urandom_range(0, 2))
            issue_request(OP_CLEAR, c0 + $urandom_range(w - 1), r0 + $urandom_range(h - 1));
        repeat ($urandom_range(1, 5))
        begin
            // The step itself reports one cell of the new generation; aim it mostly
            // inside the patch, now and then anywhere in the address range.
            if ($urandom_range(4) == 0)
                issue_request(OP_STEP, $urandom_range(63), $urandom_range(63));
            else
                issue_request(OP_STEP, c0 + $urandom_range(w - 1), r0 + $urandom_range(h - 1));
            repeat ($urandom_range(0, 2))
                issue_request(OP_READ, c0 + $urandom_range(w - 1), r0 + $urandom_range(h - 1));
        end
    endtask

    // Unstructured requests over the whole address range, a quarter of them off the grid.
    task automatic random_noise();
        repeat ($urandom_range(1, 8))
            issue_request(op_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, sent back to back. An empty grid reads dead with a zero count.
        issue_request(OP_READ, 0, 0);
        issue_request(OP_SET, 0, 0);
        // Setting a live cell changes nothing.
        issue_request(OP_SET, 0, 0);
        issue_request(OP_SET, 63, 47);
        issue_request(OP_READ, 63, 47);
        // Off-grid addresses: set and clear do nothing and the cell always reads dead.
        issue_request(OP_SET, 63, 48);
        issue_request(OP_READ, 63, 63);
        issue_request(OP_CLEAR, 5, 63);
        // Clearing a dead cell changes nothing; then a real clear.
        issue_request(OP_CLEAR, 10, 10);
        issue_request(OP_CLEAR, 0, 0);
        // A horizontal blinker turns vertical; the lone corner cell dies of isolation.
        issue_request(OP_SET, 30, 20);
        issue_request(OP_SET, 31, 20);
        issue_request(OP_SET, 32, 20);
        issue_request(OP_STEP, 31, 19);
        // A step addressed off the grid still reports the population.
        issue_request(OP_STEP, 63, 63);
        // A glider in the top left corner, where the missing neighbours matter.
        issue_request(OP_SET, 1, 0);
        issue_request(OP_SET, 2, 1);
        issue_request(OP_SET, 0, 2);
        issue_request(OP_SET, 1, 2);
        issue_request(OP_SET, 2, 2);
        issue_request(OP_STEP, 1, 1);
        issue_request(OP_STEP, 0, 63);
        issue_request(OP_READ, 2, 2);
        issue_request(OP_CLEAR, 63, 47);

        // Random part in four idling phases: none, heavy, none, moderate.
        while (issued < TOTAL_REQUESTS)
        begin
            case (issued * 4 / TOTAL_REQUESTS)
                1: idle_pct = 67;
                3: idle_pct = 32;
                default: idle_pct = 0;
            endcase
            if ($urandom_range(99) < 65)
                grow_patch();
            else
                random_noise();
        end

        // Let the last request register, drain every result, then allow the block
        // time to show any stray result.
        start <= 1'b0;
        @(posedge clk);
        while (awaited_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Coverage: %0d requests, %0d generation steps, %0d off-grid addresses;",
                 issued, steps_issued, off_grid_issued);
        $display("%0d results compared against the shadow grid.", compared_count);
        if (fail_count == 0 && awaited_count == 0)
            $display("PASS life_cellular_automaton_unit");
        else
            $display("FAIL life_cellular_automaton_unit");
        $finish;
    end

endmodule
